/* design/lprd_pkg.sv */
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared types and constants for the lighting packet run-length decoder.
// ----------------------------------------------------------------------------
package lprd_pkg;

    localparam int DMX_SLOTS        = 512;
    localparam int MAX_PACKET_BYTES = 1500;

    localparam int BPOS_W     = $clog2(MAX_PACKET_BYTES + 1);
    localparam int POS_W      = $clog2(DMX_SLOTS + 1);
    localparam int CMP_W      = (POS_W > 8) ? POS_W : 8;
    localparam int SLOT_IDX_W = 9;
    localparam int LEN_W      = 10;
    localparam int ADDR_W     = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BPOS_W-1:0] BP_START_LO  = BPOS_W'(6);
    localparam logic [BPOS_W-1:0] BP_START_HI  = BPOS_W'(7);
    localparam logic [BPOS_W-1:0] BP_COUNT_LO  = BPOS_W'(8);
    localparam logic [BPOS_W-1:0] BP_COUNT_HI  = BPOS_W'(9);
    localparam logic [BPOS_W-1:0] BP_FLAGS     = BPOS_W'(14);
    localparam logic [BPOS_W-1:0] BP_DATA      = BPOS_W'(15);
    localparam logic [BPOS_W-1:0] BP_MAX       = BPOS_W'(MAX_PACKET_BYTES);
    localparam logic [BPOS_W-1:0] BP_LAST      = BPOS_W'(MAX_PACKET_BYTES - 1);

    localparam logic [7:0] ESC_BYTE        = 8'h80;
    localparam int         FLAG_COMPRESSED = 0;

    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SEEN  = 2'd1,
        ESC_COUNT = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic                  a_valid;
        logic [SLOT_IDX_W-1:0] a_index;
        logic [7:0]            a_value;
        logic [7:0]            a_count;
        logic                  b_valid;
        logic [SLOT_IDX_W-1:0] b_index;
        logic [7:0]            b_value;
        logic                  rep_valid;
        logic                  rep_status;
        logic [ADDR_W-1:0]     rep_start;
        logic [LEN_W-1:0]      rep_length;
    } cmd_t;

    typedef struct packed {
        logic                  item_kind;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [7:0]            slot_value;
        logic [7:0]            repeat_count;
        logic                  packet_status;
        logic [ADDR_W-1:0]     start_slot;
        logic [LEN_W-1:0]      decoded_length;
        logic                  final_for_input;
    } res_t;

endpackage

/* design/lprd_front.sv */
// ----------------------------------------------------------------------------
// lprd_front
// Accepts packet bytes, tracks header and escape state, and turns each byte
// into one command holding up to two runs and an end report.
// ----------------------------------------------------------------------------
module lprd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          packet_byte,
    input  logic                end_of_packet,
    input  logic                queue_full,
    output logic                push,
    output lprd_pkg::cmd_t      push_cmd
);

    logic [lprd_pkg::BPOS_W-1:0] bytepos_reg, bytepos_next;
    logic [lprd_pkg::ADDR_W-1:0] start_reg, start_next;
    logic [lprd_pkg::ADDR_W-1:0] limit_reg, limit_next;
    logic                        compressed_reg, compressed_next;
    lprd_pkg::esc_phase_t        phase_reg, phase_next;
    logic [7:0]                  held_reg, held_next;
    logic [lprd_pkg::POS_W-1:0]  outpos_reg, outpos_next;

    logic                        accept;
    logic                        active;
    logic                        is_data;
    logic                        last;
    logic [lprd_pkg::POS_W-1:0]  lim;
    logic                        req_a;
    logic                        req_b;
    logic [7:0]                  req_val;
    logic [7:0]                  req_cnt;
    logic [lprd_pkg::POS_W-1:0]  room;
    logic [7:0]                  a_cnt;
    logic                        a_ok;
    logic                        b_ok;
    logic [lprd_pkg::POS_W-1:0]  op1;
    logic [lprd_pkg::POS_W-1:0]  op2;
    logic                        short_pkt;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign active   = bytepos_reg < lprd_pkg::BP_MAX;
    assign is_data  = active && (bytepos_reg >= lprd_pkg::BP_DATA);
    assign last     = end_of_packet || (bytepos_reg == lprd_pkg::BP_LAST);

    always_comb
    begin
        if (compressed_reg)
        begin
            lim = lprd_pkg::POS_W'(lprd_pkg::DMX_SLOTS);
        end
        else if (limit_reg < lprd_pkg::ADDR_W'(lprd_pkg::DMX_SLOTS))
        begin
            lim = lprd_pkg::POS_W'(limit_reg);
        end
        else
        begin
            lim = lprd_pkg::POS_W'(lprd_pkg::DMX_SLOTS);
        end
    end

    // escape phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (is_data && compressed_reg)
        begin
            unique case (phase_reg)
                lprd_pkg::ESC_SEEN:
                begin
                    phase_next = last ? lprd_pkg::ESC_NONE : lprd_pkg::ESC_COUNT;
                end
                lprd_pkg::ESC_COUNT:
                begin
                    phase_next = lprd_pkg::ESC_NONE;
                end
                lprd_pkg::ESC_NONE:
                begin
                    if ((outpos_reg < lim) && (packet_byte == lprd_pkg::ESC_BYTE) && !last)
                    begin
                        phase_next = lprd_pkg::ESC_SEEN;
                    end
                end
                default:
                begin
                    phase_next = lprd_pkg::ESC_NONE;
                end
            endcase
        end
        if (end_of_packet)
        begin
            phase_next = lprd_pkg::ESC_NONE;
        end
    end

    // run requests from the escape phase
    always_comb
    begin
        req_a     = 1'b0;
        req_b     = 1'b0;
        req_val   = packet_byte;
        req_cnt   = 8'd1;
        held_next = held_reg;
        if (is_data)
        begin
            if (!compressed_reg)
            begin
                req_a = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    lprd_pkg::ESC_SEEN:
                    begin
                        if (last)
                        begin
                            req_a   = 1'b1;
                            req_b   = 1'b1;
                            req_val = lprd_pkg::ESC_BYTE;
                        end
                        else
                        begin
                            held_next = packet_byte;
                        end
                    end
                    lprd_pkg::ESC_COUNT:
                    begin
                        req_a   = 1'b1;
                        req_cnt = held_reg;
                    end
                    lprd_pkg::ESC_NONE:
                    begin
                        req_a = (outpos_reg < lim)
                                && !((packet_byte == lprd_pkg::ESC_BYTE) && !last);
                    end
                    default:
                    begin
                        req_a = 1'b0;
                    end
                endcase
            end
        end
        if (end_of_packet)
        begin
            held_next = 8'd0;
        end
    end

    // run clamping against the output limit
    always_comb
    begin
        room  = lim - outpos_reg;
        a_ok  = req_a && (req_cnt != 8'd0) && (outpos_reg < lim);
        if (lprd_pkg::CMP_W'(req_cnt) > lprd_pkg::CMP_W'(room))
        begin
            a_cnt = 8'(room);
        end
        else
        begin
            a_cnt = req_cnt;
        end
        op1  = a_ok ? (outpos_reg + lprd_pkg::POS_W'(a_cnt)) : outpos_reg;
        b_ok = req_b && (op1 < lim);
        op2  = b_ok ? (op1 + lprd_pkg::POS_W'(1)) : op1;
    end

    // header capture, position counters and command build
    always_comb
    begin
        bytepos_next    = bytepos_reg;
        start_next      = start_reg;
        limit_next      = limit_reg;
        compressed_next = compressed_reg;
        outpos_next     = op2;
        short_pkt       = active && (bytepos_reg < lprd_pkg::BP_DATA);

        if (active)
        begin
            bytepos_next = bytepos_reg + lprd_pkg::BPOS_W'(1);
            if (bytepos_reg == lprd_pkg::BP_START_LO)
            begin
                start_next = {8'h00, packet_byte};
            end
            else if (bytepos_reg == lprd_pkg::BP_START_HI)
            begin
                start_next = {packet_byte, start_reg[7:0]};
            end
            else if (bytepos_reg == lprd_pkg::BP_COUNT_LO)
            begin
                limit_next = {8'h00, packet_byte};
            end
            else if (bytepos_reg == lprd_pkg::BP_COUNT_HI)
            begin
                limit_next = {packet_byte, limit_reg[7:0]};
            end
            else if (bytepos_reg == lprd_pkg::BP_FLAGS)
            begin
                compressed_next = packet_byte[lprd_pkg::FLAG_COMPRESSED];
            end
        end

        push_cmd            = '0;
        push_cmd.a_valid    = a_ok;
        push_cmd.a_index    = lprd_pkg::SLOT_IDX_W'(outpos_reg);
        push_cmd.a_value    = req_val;
        push_cmd.a_count    = a_cnt;
        push_cmd.b_valid    = b_ok;
        push_cmd.b_index    = lprd_pkg::SLOT_IDX_W'(op1);
        push_cmd.b_value    = packet_byte;
        push_cmd.rep_valid  = end_of_packet;
        push_cmd.rep_status = short_pkt ? lprd_pkg::STATUS_SHORT : lprd_pkg::STATUS_OK;
        push_cmd.rep_start  = short_pkt ? '0 : start_next;
        push_cmd.rep_length = short_pkt ? '0 : lprd_pkg::LEN_W'(op2);

        if (end_of_packet)
        begin
            bytepos_next    = '0;
            start_next      = '0;
            limit_next      = '0;
            compressed_next = 1'b0;
            outpos_next     = '0;
        end
    end

    assign push = accept && (push_cmd.a_valid || push_cmd.b_valid || push_cmd.rep_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytepos_reg    <= '0;
            start_reg      <= '0;
            limit_reg      <= '0;
            compressed_reg <= 1'b0;
            phase_reg      <= lprd_pkg::ESC_NONE;
            held_reg       <= 8'd0;
            outpos_reg     <= '0;
        end
        else if (accept)
        begin
            bytepos_reg    <= bytepos_next;
            start_reg      <= start_next;
            limit_reg      <= limit_next;
            compressed_reg <= compressed_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            outpos_reg     <= outpos_next;
        end
    end

endmodule

/* design/lprd_queue.sv */
// ----------------------------------------------------------------------------
// lprd_queue
// Short command queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module lprd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lprd_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output lprd_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);

    lprd_pkg::cmd_t                   entry_reg [lprd_pkg::QUEUE_DEPTH];
    logic [lprd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [lprd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [lprd_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [lprd_pkg::QUEUE_CNT_W-1:0] count_next;

    assign full     = count_reg == lprd_pkg::QUEUE_CNT_W'(lprd_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + lprd_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lprd_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lprd_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lprd_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue pushed while full");

endmodule

/* design/lprd_back.sv */
// ----------------------------------------------------------------------------
// lprd_back
// Expands each queued command into its results, one per cycle while out_stall is
// low, through an output register.
// ----------------------------------------------------------------------------
module lprd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lprd_pkg::cmd_t      head_cmd,
    input  logic                queue_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output lprd_pkg::res_t      res
);

    logic           done_a_reg, done_a_next;
    logic           done_b_reg, done_b_next;
    logic           out_valid_reg;
    lprd_pkg::res_t res_reg;
    lprd_pkg::res_t res_next;
    logic           load;
    logic           pend_a;
    logic           pend_b;

    assign load   = !queue_empty && (!out_valid_reg || !out_stall);
    assign pend_a = head_cmd.a_valid && !done_a_reg;
    assign pend_b = head_cmd.b_valid && !done_b_reg;

    always_comb
    begin
        res_next    = '0;
        done_a_next = done_a_reg;
        done_b_next = done_b_reg;
        pop         = 1'b0;
        if (pend_a)
        begin
            res_next.item_kind       = lprd_pkg::KIND_RUN;
            res_next.slot_index      = head_cmd.a_index;
            res_next.slot_value      = head_cmd.a_value;
            res_next.repeat_count    = head_cmd.a_count;
            res_next.final_for_input = !head_cmd.b_valid && !head_cmd.rep_valid;
            done_a_next              = 1'b1;
        end
        else if (pend_b)
        begin
            res_next.item_kind       = lprd_pkg::KIND_RUN;
            res_next.slot_index      = head_cmd.b_index;
            res_next.slot_value      = head_cmd.b_value;
            res_next.repeat_count    = 8'd1;
            res_next.final_for_input = !head_cmd.rep_valid;
            done_b_next              = 1'b1;
        end
        else
        begin
            res_next.item_kind       = lprd_pkg::KIND_REPORT;
            res_next.packet_status   = head_cmd.rep_status;
            res_next.start_slot      = head_cmd.rep_start;
            res_next.decoded_length  = head_cmd.rep_length;
            res_next.final_for_input = 1'b1;
        end
        if (load && res_next.final_for_input)
        begin
            pop         = 1'b1;
            done_a_next = 1'b0;
            done_b_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_a_reg    <= 1'b0;
            done_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                done_a_reg    <= done_a_next;
                done_b_reg    <= done_b_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.item_kind == lprd_pkg::KIND_RUN))
        |-> (res_reg.repeat_count != 8'd0))
        else $error("data run with zero count");

    a_report_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.item_kind == lprd_pkg::KIND_REPORT))
        |-> res_reg.final_for_input)
        else $error("report not marked final");

endmodule

/* design/lighting_packet_rle_decoder.sv */
// ----------------------------------------------------------------------------
// lighting_packet_rle_decoder
// Escape-byte run-length decoder for lighting-control packets: header
// capture, channel data runs and an end-of-packet report.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle with no bubbles for as long as the
// output side keeps up. Each byte yields zero to three result items (at most
// two literal runs plus the end report); the output register delivers one
// item per cycle while out_stall is low, so a byte's items leave one at a time and
// the four-entry command queue between the byte decoder and the result
// expander absorbs the difference before input stall is raised. A byte's
// command is registered in the queue, and its first result then in the output register.
module lighting_packet_rle_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  packet_byte,
    input  logic        end_of_packet,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [8:0]  slot_index,
    output logic [7:0]  slot_value,
    output logic [7:0]  repeat_count,
    output logic        packet_status,
    output logic [15:0] start_slot,
    output logic [9:0]  decoded_length,
    output logic        final_for_input
);

    lprd_pkg::cmd_t push_cmd;
    lprd_pkg::cmd_t head_cmd;
    lprd_pkg::res_t res;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    lprd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .packet_byte   (packet_byte),
        .end_of_packet (end_of_packet),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    lprd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    lprd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    assign item_kind       = res.item_kind;
    assign slot_index      = res.slot_index;
    assign slot_value      = res.slot_value;
    assign repeat_count    = res.repeat_count;
    assign packet_status   = res.packet_status;
    assign start_slot      = res.start_slot;
    assign decoded_length  = res.decoded_length;
    assign final_for_input = res.final_for_input;

endmodule

/* sim/packet_decode_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_decode_check
// Watches both channels of the lighting packet run-length decoder, predicts
// the run and report items of every accepted packet byte and compares each
// accepted result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module packet_decode_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  packet_byte,
    input  logic        end_of_packet,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        item_kind,
    input  logic [8:0]  slot_index,
    input  logic [7:0]  slot_value,
    input  logic [7:0]  repeat_count,
    input  logic        packet_status,
    input  logic [15:0] start_slot,
    input  logic [9:0]  decoded_length,
    input  logic        final_for_input,
    output int          failures,
    output int          pending
);

    localparam int MIN_PACKET = 16;

    logic [lprd_pkg::BPOS_W-1:0] byte_pos;
    logic [15:0]                 start_reg;
    logic [15:0]                 count_reg;
    logic                        compressed;
    lprd_pkg::esc_phase_t        esc;
    logic [7:0]                  held;
    logic [9:0]                  out_pos;

    lprd_pkg::res_t predicted_runs[$];
    lprd_pkg::res_t batch [3];
    int             batch_n;

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    function automatic void clear_state();
        byte_pos   = '0;
        start_reg  = '0;
        count_reg  = '0;
        compressed = 1'b0;
        esc        = lprd_pkg::ESC_NONE;
        held       = '0;
        out_pos    = '0;
    endfunction

    function automatic int slot_cap();
        int cap;
        cap = lprd_pkg::DMX_SLOTS;
        if (!compressed && int'(count_reg) < cap)
            cap = int'(count_reg);
        return cap;
    endfunction

    function automatic void emit_run(input logic [7:0] val, input logic [7:0] cnt);
        lprd_pkg::res_t r;
        int             cap;
        int             n;
        cap = slot_cap();
        n = int'(cnt);
        if (n == 0 || int'(out_pos) >= cap)
            return;
        if (n > cap - int'(out_pos))
            n = cap - int'(out_pos);
        r = '0;
        r.item_kind    = lprd_pkg::KIND_RUN;
        r.slot_index   = out_pos[8:0];
        r.slot_value   = val;
        r.repeat_count = n[7:0];
        batch[batch_n] = r;
        batch_n++;
        out_pos = out_pos + n[9:0];
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eop);
        logic [lprd_pkg::BPOS_W-1:0] pos;
        logic                        last;
        lprd_pkg::res_t              r;
        int                          total;
        batch_n = 0;
        pos = byte_pos;
        if (pos < lprd_pkg::BP_MAX)
        begin
            last = eop || pos == lprd_pkg::BP_LAST;
            if (pos == lprd_pkg::BP_START_LO)
                start_reg = {8'h00, b};
            else if (pos == lprd_pkg::BP_START_HI)
                start_reg[15:8] = b;
            else if (pos == lprd_pkg::BP_COUNT_LO)
                count_reg = {8'h00, b};
            else if (pos == lprd_pkg::BP_COUNT_HI)
                count_reg[15:8] = b;
            else if (pos == lprd_pkg::BP_FLAGS)
                compressed = b[lprd_pkg::FLAG_COMPRESSED];
            else if (pos >= lprd_pkg::BP_DATA)
            begin
                if (!compressed)
                    emit_run(b, 8'd1);
                else if (esc == lprd_pkg::ESC_SEEN)
                begin
                    if (last)
                    begin
                        emit_run(lprd_pkg::ESC_BYTE, 8'd1);
                        emit_run(b, 8'd1);
                        esc = lprd_pkg::ESC_NONE;
                    end
                    else
                    begin
                        held = b;
                        esc = lprd_pkg::ESC_COUNT;
                    end
                end
                else if (esc == lprd_pkg::ESC_COUNT)
                begin
                    emit_run(b, held);
                    esc = lprd_pkg::ESC_NONE;
                end
                else if (int'(out_pos) < slot_cap())
                begin
                    if (b == lprd_pkg::ESC_BYTE && !last)
                        esc = lprd_pkg::ESC_SEEN;
                    else
                        emit_run(b, 8'd1);
                end
            end
            byte_pos = pos + lprd_pkg::BPOS_W'(1);
        end
        if (eop)
        begin
            total = (pos < lprd_pkg::BP_MAX) ? int'(pos) + 1 : lprd_pkg::MAX_PACKET_BYTES;
            r = '0;
            r.item_kind = lprd_pkg::KIND_REPORT;
            if (total < MIN_PACKET)
                r.packet_status = lprd_pkg::STATUS_SHORT;
            else
            begin
                r.packet_status  = lprd_pkg::STATUS_OK;
                r.start_slot     = start_reg;
                r.decoded_length = out_pos;
            end
            batch[batch_n] = r;
            batch_n++;
            clear_state();
        end
        if (batch_n > 0)
            batch[batch_n-1].final_for_input = 1'b1;
        for (int i = 0; i < batch_n; i++)
            predicted_runs.push_back(batch[i]);
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        lprd_pkg::res_t want;
        if (!rst_n)
        begin
            clear_state();
            predicted_runs.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_runs.size() == 0)
                begin
                    $error("result item with nothing expected");
                    failures++;
                end
                else
                begin
                    want = predicted_runs.pop_front();
                    check_field("item_kind", int'(want.item_kind), int'(item_kind));
                    check_field("slot_index", int'(want.slot_index), int'(slot_index));
                    check_field("slot_value", int'(want.slot_value), int'(slot_value));
                    check_field("repeat_count", int'(want.repeat_count),
                                int'(repeat_count));
                    check_field("packet_status", int'(want.packet_status),
                                int'(packet_status));
                    check_field("start_slot", int'(want.start_slot), int'(start_slot));
                    check_field("decoded_length", int'(want.decoded_length),
                                int'(decoded_length));
                    check_field("final_for_input", int'(want.final_for_input),
                                int'(final_for_input));
                end
            end
            if (in_valid && !in_stall)
                decode_byte(packet_byte, end_of_packet);
        end
        pending = predicted_runs.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the lighting packet run-length decoder with directed and random
// packets (short, raw, compressed, clamped and oversized) under random
// stalls on both sides, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 360;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  packet_byte = 8'h00;
    logic        end_of_packet = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        item_kind;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic [7:0]  repeat_count;
    logic        packet_status;
    logic [15:0] start_slot;
    logic [9:0]  decoded_length;
    logic        final_for_input;

    int   failures;
    int   pending;
    int   cycle_count = 0;
    int   idle_pct = 22;
    int   bytes_sent = 0;
    logic hold_req = 1'b0;
    logic out_hold = 1'b0;
    logic [7:0] pkt[$];

    lighting_packet_rle_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_byte     (packet_byte),
        .end_of_packet   (end_of_packet),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .item_kind       (item_kind),
        .slot_index      (slot_index),
        .slot_value      (slot_value),
        .repeat_count    (repeat_count),
        .packet_status   (packet_status),
        .start_slot      (start_slot),
        .decoded_length  (decoded_length),
        .final_for_input (final_for_input)
    );

    packet_decode_check check_u (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_byte     (packet_byte),
        .end_of_packet   (end_of_packet),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .item_kind       (item_kind),
        .slot_index      (slot_index),
        .slot_value      (slot_value),
        .repeat_count    (repeat_count),
        .packet_status   (packet_status),
        .start_slot      (start_slot),
        .decoded_length  (decoded_length),
        .final_for_input (final_for_input),
        .failures        (failures),
        .pending         (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= out_hold || ($urandom_range(0, 99) < idle_pct);

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (120) @(posedge clk);
        out_hold <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        packet_byte   <= b;
        end_of_packet <= eop;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    task automatic put_header(input logic [15:0] first_slot, input logic [15:0] slots,
                              input logic [7:0] flags);
        pkt.delete();
        for (int i = 0; i < 6; i++)
            pkt.push_back(8'($urandom));
        pkt.push_back(first_slot[7:0]);
        pkt.push_back(first_slot[15:8]);
        pkt.push_back(slots[7:0]);
        pkt.push_back(slots[15:8]);
        for (int i = 0; i < 4; i++)
            pkt.push_back(8'($urandom));
        pkt.push_back(flags);
    endtask

    task automatic put_run(input logic [7:0] cnt, input logic [7:0] val);
        pkt.push_back(lprd_pkg::ESC_BYTE);
        pkt.push_back(cnt);
        pkt.push_back(val);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    // oversized packet with zero-count filler; lead sets where the final escape lands
    task automatic long_packet(input int lead);
        put_header(16'h1234, 16'($urandom), 8'h01);
        for (int i = 0; i < lead; i++)
            pkt.push_back(8'h11);
        while (pkt.size() + 3 <= int'(lprd_pkg::BP_LAST))
            put_run(8'h00, 8'($urandom));
        pkt.push_back(lprd_pkg::ESC_BYTE);
        if (pkt.size() < lprd_pkg::MAX_PACKET_BYTES)
            pkt.push_back(8'h37);
        pkt.push_back(lprd_pkg::ESC_BYTE);
        pkt.push_back(8'($urandom));
        send_pkt();
    endtask

    task automatic random_packet();
        int          mode;
        int          n;
        int          roll;
        logic [15:0] slots;
        logic [7:0]  flags;
        logic [7:0]  cnt;
        mode = int'($urandom_range(0, 9));
        pkt.delete();
        if (mode < 2)
        begin
            n = int'($urandom_range(1, 15));
            for (int i = 0; i < n; i++)
                pkt.push_back(8'($urandom));
        end
        else
        begin
            roll = int'($urandom_range(0, 3));
            case (roll)
                0:       slots = 16'($urandom_range(0, 8));
                1:       slots = 16'($urandom_range(9, 60));
                2:       slots = 16'hFFFF;
                default: slots = 16'($urandom);
            endcase
            flags = 8'($urandom);
            put_header(16'($urandom), slots, flags);
            n = int'($urandom_range(1, 16));
            for (int i = 0; i < n; i++)
            begin
                roll = int'($urandom_range(0, 99));
                cnt = (roll < 5) ? 8'h00 : 8'($urandom);
                if (flags[lprd_pkg::FLAG_COMPRESSED] && roll < 35)
                    put_run(cnt, 8'($urandom));
                else
                    pkt.push_back(8'($urandom));
            end
            if (flags[lprd_pkg::FLAG_COMPRESSED])
            begin
                roll = int'($urandom_range(0, 9));
                if (roll == 0)
                    pkt.push_back(lprd_pkg::ESC_BYTE);
                else if (roll == 1)
                begin
                    pkt.push_back(lprd_pkg::ESC_BYTE);
                    pkt.push_back(8'($urandom));
                end
            end
        end
        send_pkt();
    endtask

    initial
    begin
        int rand_start;
        int npk;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest packet and header-only packet
        pkt.push_back(8'hFF);
        send_pkt();
        put_header(16'hFFFF, 16'hFFFF, 8'h01);
        send_pkt();

        // raw, one slot allowed, extreme start slot
        put_header(16'hFFFF, 16'h0001, 8'h00);
        pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        send_pkt();

        // raw with zero slot count
        put_header(16'h0000, 16'h0000, 8'h00);
        pkt.push_back(8'h5A);
        send_pkt();

        // compressed runs up to the slot limit, zero count, trailing escape
        put_header(16'h00FF, 16'h0000, 8'hFF);
        put_run(8'hFF, 8'h00);
        put_run(8'h00, 8'h55);
        put_run(8'hFF, 8'hAA);
        put_run(8'h05, 8'h01);
        pkt.push_back(8'h12);
        pkt.push_back(lprd_pkg::ESC_BYTE);
        send_pkt();

        // escape as last byte
        put_header(16'h0100, 16'h0000, 8'h01);
        put_run(8'h03, 8'h7F);
        pkt.push_back(lprd_pkg::ESC_BYTE);
        send_pkt();

        // escape with one byte left: two literals and the report from one byte
        put_header(16'h0200, 16'h0000, 8'h01);
        pkt.push_back(8'h01);
        pkt.push_back(lprd_pkg::ESC_BYTE);
        pkt.push_back(8'h42);
        send_pkt();

        // raw clamped at the channel limit
        put_header(16'h0000, 16'hFFFF, 8'hFE);
        for (int i = 0; i < 520; i++)
            pkt.push_back(8'($urandom));
        send_pkt();

        // receiver holds off while bytes keep coming
        idle_pct = 0;
        hold_req = 1'b1;
        put_header(16'h0042, 16'd200, 8'h00);
        for (int i = 0; i < 120; i++)
            pkt.push_back(8'($urandom));
        send_pkt();
        idle_pct = 22;

        // sender pauses until everything is out
        drain();

        long_packet(1);
        long_packet(2);

        rand_start = bytes_sent;
        npk = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            idle_pct = (npk >= 3 && npk < 7) ? 0 : 22;
            random_packet();
            npk++;
        end
        idle_pct = 22;

        drain();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
